// ===== hdl/tfn_pkg.sv =====
// Shared constants for the triangle face normal unit.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
    localparam int NUM_AXES  = 3;
    localparam int OUT_WIDTH = 16;
endpackage
`default_nettype wire

// ===== hdl/triangle_face_normal_unit.sv =====
// Top level: pipelined unit face normal of one triangle in fixed point.
// Throughput: one triangle per cycle while the pipeline is not held;
// one square root stage and one divide stage per result bit.
// The whole pipeline holds when the output register is full and not taken.
// Reset (synchronous, active low) clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_unit #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_z,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_x,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_y,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_z,
    output logic                               o_degenerate
);
    localparam int NA  = tfn_pkg::NUM_AXES;
    localparam int OW  = tfn_pkg::OUT_WIDTH;
    localparam int W   = COORD_WIDTH;
    localparam int EW  = W + 1;
    localparam int PW  = 2 * W + 1;
    localparam int NW  = 2 * W + 2;
    localparam int MW  = 2 * W + 1;
    localparam int LO  = (MW + 1) / 2;
    localparam int HI  = MW - LO;
    localparam int SW  = 4 * W + 4;
    localparam int RW  = 2 * W + 2;
    localparam int QW  = NORMAL_FRAC_BITS + 1;
    localparam int DW  = RW + 1;
    localparam int XW  = (QW > OW) ? QW : OW;
    localparam int NST = 8 + RW + QW;

    typedef struct packed {
        logic [NA-1:0][MW-1:0] mag;
        logic [NA-1:0]         neg;
    } t_side;

    logic en;
    logic r_vld [NST];

    assign en          = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < NST; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Edge vectors.
    logic signed [EW-1:0] r_ea [NA];
    logic signed [EW-1:0] r_eb [NA];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ea[0] <= EW'(i_a_x) - EW'(i_b_x);
            r_ea[1] <= EW'(i_a_y) - EW'(i_b_y);
            r_ea[2] <= EW'(i_a_z) - EW'(i_b_z);
            r_eb[0] <= EW'(i_b_x) - EW'(i_c_x);
            r_eb[1] <= EW'(i_b_y) - EW'(i_c_y);
            r_eb[2] <= EW'(i_b_z) - EW'(i_c_z);
        end
    end

    logic signed [PW-1:0] r_p   [NA];
    logic signed [PW-1:0] r_q   [NA];
    logic signed [NW-1:0] r_n   [NA];
    logic [2*HI-1:0]      r_hh  [NA];
    logic [HI+LO-1:0]     r_hl  [NA];
    logic [2*LO-1:0]      r_ll  [NA];
    logic [SW-1:0]        r_sqr [NA];
    t_side                r_sd  [RW+4];

    generate
        for (genvar k = 0; k < NA; k++) begin : g_axis
            localparam int K1 = (k + 1) % NA;
            localparam int K2 = (k + 2) % NA;
            logic signed [2*EW-1:0] prod_p;
            logic signed [2*EW-1:0] prod_q;
            logic [HI-1:0]          hi;
            logic [LO-1:0]          lo;
            logic [2*HI-1:0]        hh;
            logic [HI+LO-1:0]       hl;
            logic [2*LO-1:0]        ll;
            assign prod_p = r_ea[K1] * r_eb[K2];
            assign prod_q = r_ea[K2] * r_eb[K1];
            assign hi = r_sd[0].mag[k][MW-1:LO];
            assign lo = r_sd[0].mag[k][LO-1:0];
            assign hh = hi * hi;
            assign hl = hi * lo;
            assign ll = lo * lo;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_p[k]   <= prod_p[PW-1:0];
                    r_q[k]   <= prod_q[PW-1:0];
                    r_n[k]   <= NW'(r_p[k]) - NW'(r_q[k]);
                    r_hh[k]  <= hh;
                    r_hl[k]  <= hl;
                    r_ll[k]  <= ll;
                    // The square is rebuilt from half-width partial products.
                    r_sqr[k] <= (SW'(r_hh[k]) << (2 * LO)) + (SW'(r_hl[k]) << (LO + 1))
                              + SW'(r_ll[k]);
                end
            end
        end
    endgenerate

    // Magnitude and sign of the cross product enter the side pipeline.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NA; k++) begin
                r_sd[0].neg[k] <= r_n[k][NW-1];
                r_sd[0].mag[k] <= r_n[k][NW-1] ? MW'(-r_n[k]) : MW'(r_n[k]);
            end
            r_sd[1] <= r_sd[0];
            r_sd[2] <= r_sd[1];
            r_sd[3] <= r_sd[2];
        end
    end

    logic [SW-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (en) r_sum <= r_sqr[0] + r_sqr[1] + r_sqr[2];
    end

    // Square root, one result bit per stage from the top pair of sum bits down.
    logic [RW+1:0] r_sr [RW];
    logic [RW-1:0] r_rt [RW];
    logic [SW-1:0] r_sx [RW];

    generate
        for (genvar j = 0; j < RW; j++) begin : g_sqrt
            logic [RW+1:0] rem_in;
            logic [RW-1:0] rt_in;
            logic [SW-1:0] sx_in;
            logic [RW+2:0] trial;
            logic [RW+2:0] tsub;
            logic          take;
            if (j == 0) begin : g_first
                assign rem_in = '0;
                assign rt_in  = '0;
                assign sx_in  = r_sum;
            end else begin : g_next
                assign rem_in = r_sr[j-1];
                assign rt_in  = r_rt[j-1];
                assign sx_in  = r_sx[j-1];
            end
            assign trial = {rem_in[RW:0], sx_in[SW-1:SW-2]};
            assign tsub  = {1'b0, rt_in, 2'b01};
            assign take  = trial >= tsub;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sr[j]   <= take ? (RW+2)'(trial - tsub) : trial[RW+1:0];
                    r_rt[j]   <= {rt_in[RW-2:0], take};
                    r_sx[j]   <= {sx_in[SW-3:0], 2'b00};
                    r_sd[j+4] <= r_sd[j+3];
                end
            end
        end
    endgenerate

    // Restoring division of each magnitude scaled by the fraction bits.
    logic [DW-1:0]          r_dr [QW][NA];
    logic [QW-1:0]          r_dq [QW][NA];
    logic [RW-1:0]          r_dl [QW];
    logic [NA-1:0]          r_dn [QW];
    logic                   r_dd [QW];

    generate
        for (genvar d = 0; d < QW; d++) begin : g_div
            logic [RW-1:0] len_in;
            logic [NA-1:0] neg_in;
            logic          deg_in;
            if (d == 0) begin : g_first
                assign len_in = r_rt[RW-1];
                assign neg_in = r_sd[RW+3].neg;
                assign deg_in = (r_rt[RW-1] == '0);
            end else begin : g_next
                assign len_in = r_dl[d-1];
                assign neg_in = r_dn[d-1];
                assign deg_in = r_dd[d-1];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dl[d] <= len_in;
                    r_dn[d] <= neg_in;
                    r_dd[d] <= deg_in;
                end
            end
            for (genvar k = 0; k < NA; k++) begin : g_lane
                logic [DW-1:0] rem_in;
                logic [QW-1:0] q_in;
                logic [DW-1:0] rem_sub;
                logic          take;
                if (d == 0) begin : g_first
                    assign rem_in = DW'(r_sd[RW+3].mag[k]);
                    assign q_in   = '0;
                end else begin : g_next
                    assign rem_in = r_dr[d-1][k];
                    assign q_in   = r_dq[d-1][k];
                end
                assign take    = rem_in >= DW'(len_in);
                assign rem_sub = take ? (rem_in - DW'(len_in)) : rem_in;
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dr[d][k] <= {rem_sub[DW-2:0], 1'b0};
                        r_dq[d][k] <= {q_in[QW-2:0], take};
                    end
                end
            end
        end
    endgenerate

    // Output register: sign restored, degenerate triangles forced to zero.
    logic [OW-1:0] r_out [NA];
    logic          r_deg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NA; k++) begin
                if (r_dd[QW-1]) begin
                    r_out[k] <= '0;
                end else if (r_dn[QW-1][k]) begin
                    r_out[k] <= OW'(-XW'(r_dq[QW-1][k]));
                end else begin
                    r_out[k] <= OW'(XW'(r_dq[QW-1][k]));
                end
            end
            r_deg <= r_dd[QW-1];
        end
    end

    assign o_normal_x   = r_out[0];
    assign o_normal_y   = r_out[1];
    assign o_normal_z   = r_out[2];
    assign o_degenerate = r_deg;
endmodule
`default_nettype wire

// ===== sim/tb_triangle_face_normal_unit.sv =====
// Self-checking testbench for the triangle face normal unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_triangle_face_normal_unit;
    localparam int CW          = 16;
    localparam int FRAC        = 14;
    localparam int LATENCY     = 8 + (2 * CW + 2) + (FRAC + 1);
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [tfn_pkg::OUT_WIDTH-1:0] nrm [tfn_pkg::NUM_AXES];
        logic                                 degen;
    } t_normal;

    class normal_scoreboard;
        t_normal pending [$];
        int      errors = 0;

        function t_wide int_sqrt(t_wide val);
            t_wide root;
            t_wide cand;
            root = 0;
            for (int b = 63; b >= 0; b--) begin
                cand = root | (t_wide'(1) << b);
                if (cand * cand <= val) begin
                    root = cand;
                end
            end
            return root;
        endfunction

        // Vertex order is a, b, c, each as x, y, z.
        function void note_triangle(t_coord vtx [9]);
            t_wide   ea [tfn_pkg::NUM_AXES];
            t_wide   eb [tfn_pkg::NUM_AXES];
            t_wide   cr [tfn_pkg::NUM_AXES];
            t_wide   va, vb, vc, sumsq, len, mag, quo;
            t_normal exp_n;
            for (int k = 0; k < tfn_pkg::NUM_AXES; k++) begin
                va = vtx[k];
                vb = vtx[3 + k];
                vc = vtx[6 + k];
                ea[k] = va - vb;
                eb[k] = vb - vc;
            end
            sumsq = 0;
            for (int k = 0; k < tfn_pkg::NUM_AXES; k++) begin
                cr[k] = ea[(k + 1) % 3] * eb[(k + 2) % 3] - ea[(k + 2) % 3] * eb[(k + 1) % 3];
                sumsq += cr[k] * cr[k];
            end
            exp_n.degen = (sumsq == 0);
            len = int_sqrt(sumsq);
            for (int k = 0; k < tfn_pkg::NUM_AXES; k++) begin
                if (exp_n.degen) begin
                    exp_n.nrm[k] = '0;
                end else begin
                    // Divide the magnitude so the quotient truncates toward zero.
                    mag = (cr[k] < 0) ? -cr[k] : cr[k];
                    quo = (mag << FRAC) / len;
                    if (cr[k] < 0) begin
                        quo = -quo;
                    end
                    exp_n.nrm[k] = quo[tfn_pkg::OUT_WIDTH-1:0];
                end
            end
            pending.insert(pending.size(), exp_n);
        endfunction

        function void check_normal(logic signed [tfn_pkg::OUT_WIDTH-1:0] nx, ny, nz,
                                   logic dg);
            t_normal e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (nx !== e.nrm[0]) begin
                $error("normal_x expected %0d actual %0d", e.nrm[0], nx);
                errors++;
            end
            if (ny !== e.nrm[1]) begin
                $error("normal_y expected %0d actual %0d", e.nrm[1], ny);
                errors++;
            end
            if (nz !== e.nrm[2]) begin
                $error("normal_z expected %0d actual %0d", e.nrm[2], nz);
                errors++;
            end
            if (dg !== e.degen) begin
                $error("degenerate expected %0b actual %0b", e.degen, dg);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   i_out_ready = 1'b0;
    t_coord i_a_x = '0, i_a_y = '0, i_a_z = '0;
    t_coord i_b_x = '0, i_b_y = '0, i_b_z = '0;
    t_coord i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic   o_in_ready, o_out_valid, o_degenerate;
    logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_x, o_normal_y, o_normal_z;

    triangle_face_normal_unit #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate)
    );

    normal_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random backpressure plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            sb.check_normal(o_normal_x, o_normal_y, o_normal_z, o_degenerate);
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_triangle(t_coord vtx [9]);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_a_x <= vtx[0]; i_a_y <= vtx[1]; i_a_z <= vtx[2];
        i_b_x <= vtx[3]; i_b_y <= vtx[4]; i_b_z <= vtx[5];
        i_c_x <= vtx[6]; i_c_y <= vtx[7]; i_c_z <= vtx[8];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_triangle(vtx);
    endtask

    task automatic send_random(int count);
        t_coord vtx [9];
        int     kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            for (int j = 0; j < 9; j++) begin
                case (kind)
                    0, 1, 2, 3: vtx[j] = t_coord'($urandom);
                    4, 5:       vtx[j] = t_coord'($signed($urandom_range(512)) - 256);
                    6:          vtx[j] = t_coord'($signed($urandom_range(8)) - 4);
                    default:    vtx[j] = t_coord'($signed($urandom_range(8192)) - 4096);
                endcase
            end
            // Occasionally force a duplicate vertex or a nearly collinear triple (b is a halved, c at 0).
            if (kind == 8) begin
                for (int j = 0; j < 3; j++) vtx[3 + j] = vtx[j];
            end else if (kind == 9) begin
                for (int j = 0; j < 3; j++) begin
                    vtx[3 + j] = vtx[j] / 2;
                    vtx[6 + j] = '0;
                end
            end
            send_triangle(vtx);
        end
    endtask

    initial begin
        t_coord vset [9];
        int     waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        vset = '{default: '0};
        send_triangle(vset);
        vset = '{default: 16'sh7fff};
        send_triangle(vset);
        vset = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh7fff, 16'sh8000};
        send_triangle(vset);
        vset = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh7fff, 16'sh7fff, 16'sh8000};
        send_triangle(vset);
        vset = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh7fff};
        send_triangle(vset);
        // Right triangles of side 256 in each axis plane, both windings in the xy plane.
        vset = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        send_triangle(vset);
        vset = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        send_triangle(vset);
        vset = '{0, 0, 0, 0, 256, 0, 0, 0, 256};
        send_triangle(vset);
        vset = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
        send_triangle(vset);
        vset = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_triangle(vset);
        vset = '{-1, -1, -1, 1, 1, 1, 3, 3, 3};
        send_triangle(vset);
        vset = '{100, -200, 300, 100, -200, 300, 5, 6, 7};
        send_triangle(vset);
        vset = '{1, 2, 3, 1, 2, 3, 1, 2, 3};
        send_triangle(vset);
        vset = '{0, 0, 0, 1, 0, 0, 0, 1, 1};
        send_triangle(vset);
        vset = '{0, 0, 0, 3, 1, 0, 0, 0, 1};
        send_triangle(vset);

        send_idle_pct = 16;
        recv_idle_pct = 55;
        hold_req = 1;
        send_random(150);
        send_idle_pct = 55;
        recv_idle_pct = 16;
        send_random(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(150);
        i_in_valid <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== triangle_face_normal_unit.f =====
hdl/tfn_pkg.sv
hdl/triangle_face_normal_unit.sv
sim/tb_triangle_face_normal_unit.sv
